// ===== hw/rtl/sbqeq_pkg.sv =====
// ----------------------------------------------------------------------------
// sbqeq_pkg
// Types, sizes and arithmetic helpers for the stereo biquad equaliser.
// ----------------------------------------------------------------------------
package sbqeq_pkg;

    localparam int NUM_BANDS   = 10;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 24;
    localparam int DELAY_BITS  = 32;
    localparam int COEF_FRAC   = COEF_BITS - 4;
    localparam int BAND_BITS   = 4;
    localparam int PROD_BITS   = COEF_BITS + DELAY_BITS;
    localparam int ACC_BITS    = PROD_BITS + 3;
    localparam int CNT_BITS    = $clog2(NUM_BANDS + 1);

    typedef enum logic [0:0] {
        CMD_FILTER = 1'b0,
        CMD_WRITE  = 1'b1
    } command_t;

    typedef enum logic [2:0] {
        SLOT_ENABLE = 3'd0,
        SLOT_A1     = 3'd1,
        SLOT_A2     = 3'd2,
        SLOT_B0     = 3'd3,
        SLOT_B1     = 3'd4,
        SLOT_B2     = 3'd5
    } coef_slot_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                          command;
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic                          end_of_block;
        logic [BAND_BITS-1:0]          band_number;
        logic [2:0]                    coef_slot;
        logic signed [COEF_BITS-1:0]   coef_value;
    } in_beat_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_result;
        logic signed [SAMPLE_BITS-1:0] right_result;
        logic                          end_of_block_out;
    } out_beat_t;

    // coefficient write broadcast to the cells
    typedef struct packed {
        logic                        wr;
        logic [BAND_BITS-1:0]        band;
        logic [2:0]                  slot;
        logic signed [COEF_BITS-1:0] value;
    } coef_wr_t;

    // sample travelling down the row
    typedef struct packed {
        logic                          valid;
        logic                          ch;
        logic signed [SAMPLE_BITS-1:0] x;
    } tok_t;

    function automatic logic signed [DELAY_BITS-1:0] sat_delay(
        input logic signed [ACC_BITS-1:0] v);
        logic signed [ACC_BITS-1:0] hi;
        logic signed [ACC_BITS-1:0] lo;
        hi = ACC_BITS'({1'b0, {(DELAY_BITS-1){1'b1}}});
        lo = -hi - ACC_BITS'(1);
        if (v > hi)
            sat_delay = hi[DELAY_BITS-1:0];
        else if (v < lo)
            sat_delay = lo[DELAY_BITS-1:0];
        else
            sat_delay = v[DELAY_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [ACC_BITS-1:0] v);
        logic signed [ACC_BITS-1:0] hi;
        logic signed [ACC_BITS-1:0] lo;
        hi = ACC_BITS'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
        lo = -hi - ACC_BITS'(1);
        if (v > hi)
            sat_sample = hi[SAMPLE_BITS-1:0];
        else if (v < lo)
            sat_sample = lo[SAMPLE_BITS-1:0];
        else
            sat_sample = v[SAMPLE_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/sbqeq_band_cell.sv =====
// ----------------------------------------------------------------------------
// sbqeq_band_cell
// One biquad band: coefficients, both channels' delays, registered feedback then feedforward datapath.
// ----------------------------------------------------------------------------
module sbqeq_band_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [sbqeq_pkg::BAND_BITS-1:0]    band_id,
    input  sbqeq_pkg::coef_wr_t                coef_wr,
    input  sbqeq_pkg::tok_t                    tok_in,
    output sbqeq_pkg::tok_t                    tok_out
);

    logic                                    en_reg;
    logic signed [sbqeq_pkg::COEF_BITS-1:0]  a1_reg, a2_reg, b0_reg, b1_reg, b2_reg;
    logic signed [sbqeq_pkg::DELAY_BITS-1:0] w1_reg [2];
    logic signed [sbqeq_pkg::DELAY_BITS-1:0] w2_reg [2];

    // stage one: feedback part, gives w
    sbqeq_pkg::tok_t                         s1_reg;
    logic signed [sbqeq_pkg::DELAY_BITS-1:0] w_reg;
    logic signed [sbqeq_pkg::DELAY_BITS-1:0] s1w1_reg, s1w2_reg;
    logic                                    s1en_reg;

    logic signed [sbqeq_pkg::DELAY_BITS-1:0] w1_cur, w2_cur;
    logic signed [sbqeq_pkg::ACC_BITS-1:0]   fb_acc, ff_acc;
    logic signed [sbqeq_pkg::DELAY_BITS-1:0] w_next;
    logic signed [sbqeq_pkg::SAMPLE_BITS-1:0] y_next;
    sbqeq_pkg::tok_t                         out_next;

    assign w1_cur = w1_reg[tok_in.ch];
    assign w2_cur = w2_reg[tok_in.ch];

    always_comb
    begin
        fb_acc = (sbqeq_pkg::ACC_BITS'(a1_reg) * sbqeq_pkg::ACC_BITS'(w1_cur)
                + sbqeq_pkg::ACC_BITS'(a2_reg) * sbqeq_pkg::ACC_BITS'(w2_cur))
                >>> sbqeq_pkg::COEF_FRAC;
        w_next = sbqeq_pkg::sat_delay(fb_acc + sbqeq_pkg::ACC_BITS'(tok_in.x));
    end

    always_comb
    begin
        ff_acc = (sbqeq_pkg::ACC_BITS'(b0_reg) * sbqeq_pkg::ACC_BITS'(w_reg)
                + sbqeq_pkg::ACC_BITS'(b1_reg) * sbqeq_pkg::ACC_BITS'(s1w1_reg)
                + sbqeq_pkg::ACC_BITS'(b2_reg) * sbqeq_pkg::ACC_BITS'(s1w2_reg))
                >>> sbqeq_pkg::COEF_FRAC;
        y_next = sbqeq_pkg::sat_sample(ff_acc);
        out_next = s1_reg;
        if (s1en_reg)
            out_next.x = y_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg  <= 1'b0;
            a1_reg  <= '0;
            a2_reg  <= '0;
            b0_reg  <= '0;
            b1_reg  <= '0;
            b2_reg  <= '0;
            w1_reg[0] <= '0;
            w1_reg[1] <= '0;
            w2_reg[0] <= '0;
            w2_reg[1] <= '0;
            s1_reg  <= '0;
            tok_out <= '0;
            s1en_reg <= 1'b0;
        end
        else
        begin
            if (coef_wr.wr && coef_wr.band == band_id)
            begin
                case (coef_wr.slot)
                    sbqeq_pkg::SLOT_ENABLE: en_reg <= (coef_wr.value != '0);
                    sbqeq_pkg::SLOT_A1:     a1_reg <= coef_wr.value;
                    sbqeq_pkg::SLOT_A2:     a2_reg <= coef_wr.value;
                    sbqeq_pkg::SLOT_B0:     b0_reg <= coef_wr.value;
                    sbqeq_pkg::SLOT_B1:     b1_reg <= coef_wr.value;
                    sbqeq_pkg::SLOT_B2:     b2_reg <= coef_wr.value;
                    default:                ;
                endcase
            end
            s1_reg   <= tok_in;
            s1en_reg <= en_reg;
            tok_out  <= out_next;
            if (tok_in.valid && en_reg)
            begin
                w1_reg[tok_in.ch] <= w_next;
                w2_reg[tok_in.ch] <= w1_cur;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        w_reg    <= w_next;
        s1w1_reg <= w1_cur;
        s1w2_reg <= w2_cur;
    end

endmodule

// ===== hw/rtl/sbqeq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbqeq_ctrl
// Beat sequencer: launches both channels into the band row, collects results.
// ----------------------------------------------------------------------------
module sbqeq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    output logic                 ready,
    input  sbqeq_pkg::in_beat_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sbqeq_pkg::out_beat_t out_data,
    output sbqeq_pkg::coef_wr_t  coef_wr,
    output sbqeq_pkg::tok_t      tok_head,
    input  sbqeq_pkg::tok_t      tok_tail
);

    sbqeq_pkg::state_t state_reg, state_next;
    logic              second_reg, second_next;
    logic              got_l_reg, got_l_next;
    logic signed [sbqeq_pkg::SAMPLE_BITS-1:0] right_reg;
    logic              eob_reg;
    sbqeq_pkg::out_beat_t res_reg;
    logic              accept;

    assign accept = valid && ready;

    always_comb
    begin
        state_next  = state_reg;
        second_next = 1'b0;
        got_l_next  = got_l_reg;
        case (state_reg)
            sbqeq_pkg::ST_IDLE:
                if (accept && in_data.command == sbqeq_pkg::CMD_FILTER)
                begin
                    state_next  = sbqeq_pkg::ST_RUN;
                    second_next = 1'b1;
                    got_l_next  = 1'b0;
                end
            sbqeq_pkg::ST_RUN:
                if (tok_tail.valid)
                begin
                    if (tok_tail.ch)
                        state_next = sbqeq_pkg::ST_OUT;
                    else
                        got_l_next = 1'b1;
                end
            sbqeq_pkg::ST_OUT:
                if (out_ready)
                    state_next = sbqeq_pkg::ST_IDLE;
            default:
                state_next = sbqeq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ready     = (state_reg == sbqeq_pkg::ST_IDLE);
        out_valid = (state_reg == sbqeq_pkg::ST_OUT);
        out_data  = res_reg;
        coef_wr.wr    = accept && in_data.command == sbqeq_pkg::CMD_WRITE;
        coef_wr.band  = in_data.band_number;
        coef_wr.slot  = in_data.coef_slot;
        coef_wr.value = in_data.coef_value;
        tok_head.valid = 1'b0;
        tok_head.ch    = 1'b0;
        tok_head.x     = in_data.left_sample;
        if (accept && in_data.command == sbqeq_pkg::CMD_FILTER)
            tok_head.valid = 1'b1;
        else if (second_reg)
        begin
            // right channel follows in the cycle after the left
            tok_head.valid = 1'b1;
            tok_head.ch    = 1'b1;
            tok_head.x     = right_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sbqeq_pkg::ST_IDLE;
            second_reg <= 1'b0;
            got_l_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            got_l_reg  <= got_l_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            right_reg <= in_data.right_sample;
            eob_reg   <= in_data.end_of_block;
        end
        res_reg.end_of_block_out <= eob_reg;
        if (tok_tail.valid && !tok_tail.ch)
            res_reg.left_result <= tok_tail.x;
        if (tok_tail.valid && tok_tail.ch)
            res_reg.right_result <= tok_tail.x;
    end

endmodule

// ===== hw/rtl/stereo_biquad_cascade_equalizer.sv =====
// ----------------------------------------------------------------------------
// stereo_biquad_cascade_equalizer
// Stereo equaliser: a row of biquad band cells, samples pass cell to cell.
// ----------------------------------------------------------------------------
//  channel  | signals                  | beat
//  in       | valid, ready, in_data    | filter pair or coefficient write
//  out      | out_valid, out_ready,    | filtered pair
//           | out_data                 |
// A filter beat sends its left then right sample down the row; each band cell
// is two register stages. The result pair is then held for hand-over. Write
// beats give nothing. Reset clears all coefficients, enables and delays at
// once. A stalled result holds the input off.
module stereo_biquad_cascade_equalizer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    output logic                 ready,
    input  sbqeq_pkg::in_beat_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sbqeq_pkg::out_beat_t out_data
);

    sbqeq_pkg::coef_wr_t coef_wr;
    sbqeq_pkg::tok_t     tok [sbqeq_pkg::NUM_BANDS+1];

    sbqeq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (valid),
        .ready    (ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .coef_wr  (coef_wr),
        .tok_head (tok[0]),
        .tok_tail (tok[sbqeq_pkg::NUM_BANDS])
    );

    for (genvar b = 0; b < sbqeq_pkg::NUM_BANDS; b++)
    begin : g_band
        sbqeq_band_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .band_id(sbqeq_pkg::BAND_BITS'(b)),
            .coef_wr(coef_wr),
            .tok_in (tok[b]),
            .tok_out(tok[b+1])
        );
    end

`ifndef ASSERT_OFF
    a_no_out_while_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !(ready && out_valid)) else $error("result pending while accepting");
    a_tail_only_running: assert property (@(posedge clk) disable iff (!rst_n)
        tok[sbqeq_pkg::NUM_BANDS].valid |-> !ready && !out_valid)
        else $error("sample left the row outside a run");
    a_write_no_tok: assert property (@(posedge clk) disable iff (!rst_n)
        coef_wr.wr |-> !tok[0].valid) else $error("write alongside a sample");
`endif

endmodule
